@@ hw/rtl/boiler_heat_and_flow_controller_top_defines.svh @@
// assertion macros shared by the checker
`ifndef BOILER_HEAT_AND_FLOW_CONTROLLER_TOP_DEFINES_SVH
`define BOILER_HEAT_AND_FLOW_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BHFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhfc checker: same-cycle property failed");

// next-cycle implication, sampled on clk, off during rst
`define BHFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhfc checker: next-cycle property failed");

`endif

@@ hw/rtl/bhfc_pkg.sv @@
`default_nettype none
package bhfc_pkg;

  // datapath widths
  localparam int ACC_W  = 56;
  localparam int PROD_W = 46;
  localparam int MULA_W = 28;
  localparam int MULB_W = 18;
  localparam int DIFF_W = 17;
  localparam int AREG_W = 34;
  localparam int BREG_W = 26;
  localparam int ROUND_SHIFT = 18;

  // arithmetic constants
  localparam logic signed [MULA_W-1:0] K_LVL = 28'sd1673600;
  localparam logic signed [MULA_W-1:0] K_FF  = 28'sd4284416;
  localparam logic signed [MULA_W-1:0] K_AMB = 28'sd1024000;
  localparam logic [AREG_W-1:0]        K_OFFSET = 34'd40960;
  localparam logic signed [ACC_W-1:0]  K_ROUND  = 56'sd131072;
  localparam logic signed [ACC_W-ROUND_SHIFT-1:0] POWER_LIMIT = 38'sd1000000;
  localparam logic [13:0] TEMP_MAX     = 14'd12800;
  localparam logic signed [13:0] LEVEL_BAND = 14'sd52;

  // flow commands
  localparam logic [4:0] INFLOW_LOW_LEVEL   = 5'd15;
  localparam logic [4:0] OUTFLOW_LOW_LEVEL  = 5'd10;
  localparam logic [4:0] INFLOW_HIGH_LEVEL  = 5'd12;
  localparam logic [4:0] OUTFLOW_HIGH_LEVEL = 5'd20;

  // register indexes
  localparam logic REG_TEMP_TARGET  = 1'b0;
  localparam logic REG_LEVEL_TARGET = 1'b1;

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    A_K_LVL, A_K_FF, A_K_AMB, A_LO, A_HI, A_BREG
  } a_sel_t;

  typedef enum logic [2:0] {
    B_LEVEL, B_INFLOW, B_ERR, B_DTI, B_DTW
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_INIT, ACC_ADD_SH, ACC_SUB, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_POWER, OUT_FLOW
  } out_op_t;

  typedef enum logic [1:0] {
    JC_NONE, JC_NO_EMIT, JC_NO_HEAT, JC_OUT_BUSY
  } jump_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    ld_areg;
    logic    ld_breg;
    logic    tick_upd;
    out_op_t out_op;
    jump_t   jc;
    step_t   target;
    logic    last;
  } ucode_t;

  typedef struct packed {
    logic emit;
    logic heat;
    logic out_busy;
  } status_t;

  localparam step_t STEP_POWER_OUT = 4'd7;
  localparam step_t STEP_FLOW      = 4'd8;
  localparam step_t STEP_SKIP      = 4'd9;

  localparam ucode_t CW_NOP = '{
    a_sel: A_K_LVL, b_sel: B_LEVEL, acc_op: ACC_HOLD, ld_areg: 1'b0,
    ld_breg: 1'b0, tick_upd: 1'b0, out_op: OUT_NONE, jc: JC_NONE,
    target: 4'd0, last: 1'b0
  };

  // control store
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = CW_NOP;
    case (s)
      4'd0: begin
        // count the tick, skip silent ticks, start level scaling
        w.tick_upd = 1'b1;
        w.jc       = JC_NO_EMIT;
        w.target   = STEP_SKIP;
      end
      4'd1: begin
        w.ld_areg = 1'b1;
        w.a_sel   = A_K_FF;
        w.b_sel   = B_INFLOW;
        w.jc      = JC_NO_HEAT;
        w.target  = STEP_FLOW;
      end
      4'd2: begin
        w.ld_breg = 1'b1;
        w.a_sel   = A_LO;
        w.b_sel   = B_ERR;
      end
      4'd3: begin
        w.acc_op = ACC_INIT;
        w.a_sel  = A_HI;
        w.b_sel  = B_ERR;
      end
      4'd4: begin
        w.acc_op = ACC_ADD_SH;
        w.a_sel  = A_BREG;
        w.b_sel  = B_DTI;
      end
      4'd5: begin
        w.acc_op = ACC_SUB;
        w.a_sel  = A_K_AMB;
        w.b_sel  = B_DTW;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.out_op = OUT_POWER;
        w.jc     = JC_OUT_BUSY;
        w.target = STEP_POWER_OUT;
        w.last   = 1'b1;
      end
      4'd8: begin
        w.out_op = OUT_FLOW;
        w.jc     = JC_OUT_BUSY;
        w.target = STEP_FLOW;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bhfc_sequencer.sv @@
`default_nettype none
module bhfc_sequencer
  import bhfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t st,
  output logic         busy,
  output ucode_t       cw
);

  step_t  step, step_next;
  logic   busy_next;
  ucode_t rom_w;
  logic   taken;

  // fetch and jump decision
  always_comb begin
    rom_w = ucode_rom(step);
    unique case (rom_w.jc)
      JC_NONE:     taken = 1'b0;
      JC_NO_EMIT:  taken = !st.emit;
      JC_NO_HEAT:  taken = !st.heat;
      JC_OUT_BUSY: taken = st.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  // control word to the datapath, output write held off while waiting
  always_comb begin
    cw = rom_w;
    if (!busy) begin
      cw = CW_NOP;
    end else if (taken) begin
      cw.out_op = OUT_NONE;
    end
  end

  // step counter
  always_comb begin
    step_next = step;
    busy_next = busy;
    priority if (start) begin
      busy_next = 1'b1;
      step_next = '0;
    end else if (busy) begin
      if (taken) begin
        step_next = rom_w.target;
      end else if (rom_w.last) begin
        busy_next = 1'b0;
        step_next = '0;
      end else begin
        step_next = step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bhfc_datapath.sv @@
`default_nettype none
module bhfc_datapath
  import bhfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [13:0]        cfg_data,
  input  wire logic               capture,
  input  wire logic signed [15:0] ambient_temp,
  input  wire logic signed [15:0] water_temp,
  input  wire logic signed [15:0] inlet_temp,
  input  wire logic [12:0]        level,
  input  wire ucode_t             cw,
  output status_t                 st,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [20:0]      heater_power,
  output logic [4:0]              inflow,
  output logic [4:0]              outflow
);

  logic [13:0] temp_target;
  logic [12:0] level_target;
  logic [1:0]  tick_count;
  logic [4:0]  last_inflow;

  logic [12:0]              lv;
  logic signed [DIFF_W-1:0] err, dti, dtw;
  logic                     high_err;

  logic [AREG_W-1:0]        areg;
  logic [BREG_W-1:0]        breg;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, prod_ext;

  logic [13:0]              tgt;
  logic signed [13:0]       level_err;
  logic signed [ACC_W-ROUND_SHIFT-1:0] quot;
  logic signed [20:0]       power_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_target  <= 14'd0;
      level_target <= 13'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_TARGET:  temp_target  <= cfg_data;
        REG_LEVEL_TARGET: level_target <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // input capture with the differences the program needs
  always_comb begin
    tgt       = (temp_target > TEMP_MAX) ? TEMP_MAX : temp_target;
    level_err = $signed({1'b0, level_target}) - $signed({1'b0, level});
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      lv       <= level;
      err      <= $signed({3'b000, tgt}) - $signed({water_temp[15], water_temp});
      dti      <= $signed({inlet_temp[15], inlet_temp})
                - $signed({water_temp[15], water_temp});
      dtw      <= $signed({water_temp[15], water_temp})
                - $signed({ambient_temp[15], ambient_temp});
      high_err <= (level_err >= LEVEL_BAND);
    end
  end

  // tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 2'd0;
    end else if (cw.tick_upd) begin
      tick_count <= (tick_count == 2'd3) ? 2'd1 : tick_count + 2'd1;
    end
  end

  // operand selection
  always_comb begin
    unique case (cw.a_sel)
      A_K_LVL: mul_a = K_LVL;
      A_K_FF:  mul_a = K_FF;
      A_K_AMB: mul_a = K_AMB;
      A_LO:    mul_a = $signed({11'd0, areg[16:0]});
      A_HI:    mul_a = $signed({11'd0, areg[33:17]});
      A_BREG:  mul_a = $signed({2'd0, breg});
      default: mul_a = '0;
    endcase
    unique case (cw.b_sel)
      B_LEVEL:  mul_b = $signed({5'd0, lv});
      B_INFLOW: mul_b = $signed({13'd0, last_inflow});
      B_ERR:    mul_b = $signed({err[DIFF_W-1], err});
      B_DTI:    mul_b = $signed({dti[DIFF_W-1], dti});
      B_DTW:    mul_b = $signed({dtw[DIFF_W-1], dtw});
      default:  mul_b = '0;
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // partial-term registers
  always_ff @(posedge clk) begin
    if (cw.ld_areg) begin
      areg <= prod[AREG_W-1:0] + K_OFFSET;
    end
    if (cw.ld_breg) begin
      breg <= prod[BREG_W-1:0];
    end
  end

  // accumulator
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    unique case (cw.acc_op)
      ACC_HOLD:   acc <= acc;
      ACC_INIT:   acc <= prod_ext + K_ROUND;
      ACC_ADD_SH: acc <= acc + (prod_ext <<< 17);
      ACC_SUB:    acc <= acc - prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      default:    acc <= acc;
    endcase
  end

  // floor shift and saturation
  always_comb begin
    quot = acc[ACC_W-1:ROUND_SHIFT];
    if (quot > POWER_LIMIT) begin
      power_sat = POWER_LIMIT[20:0];
    end else if (quot < -POWER_LIMIT) begin
      power_sat = -(POWER_LIMIT[20:0]);
    end else begin
      power_sat = quot[20:0];
    end
  end

  // output register and last inflow
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_inflow <= 5'd0;
    end else begin
      if (cw.out_op != OUT_NONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cw.out_op)
        OUT_NONE: ;
        OUT_POWER: begin
          last_inflow <= 5'd0;
        end
        OUT_FLOW: begin
          last_inflow <= high_err ? INFLOW_HIGH_LEVEL : INFLOW_LOW_LEVEL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.out_op)
      OUT_NONE: ;
      OUT_POWER: begin
        heater_power <= power_sat;
        inflow       <= 5'd0;
        outflow      <= 5'd0;
      end
      OUT_FLOW: begin
        heater_power <= '0;
        inflow       <= high_err ? INFLOW_HIGH_LEVEL : INFLOW_LOW_LEVEL;
        outflow      <= high_err ? OUTFLOW_HIGH_LEVEL : OUTFLOW_LOW_LEVEL;
      end
      default: ;
    endcase
  end

  // status to the sequencer
  always_comb begin
    st.emit     = (tick_count == 2'd3);
    st.heat     = (err > 0);
    st.out_busy = out_valid && out_stall;
  end

endmodule
`default_nettype wire

@@ hw/rtl/boiler_heat_and_flow_controller_top.sv @@
// a heating tick runs microprogram steps 0 to 7, a flow tick steps 0, 1 and
// 8, a silent tick steps 0 and 9 and gives no result; a new tick is taken
// only once the last one is through, the steps sharing one 28x18 multiplier;
// an output stall holds the sequencer at its output step
// reset (synchronous, rst high): sequencer idle, tick counter, last inflow and
// output valid cleared, temp_target 0, level_target 2048
`default_nettype none
module boiler_heat_and_flow_controller_top
  import bhfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [13:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] ambient_temp,
  input  wire logic signed [15:0] water_temp,
  input  wire logic signed [15:0] inlet_temp,
  input  wire logic [12:0]        level,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [20:0]      heater_power,
  output logic [4:0]              inflow,
  output logic [4:0]              outflow
);

  logic    busy;
  logic    in_xfer;
  ucode_t  cw;
  status_t st;

  // input transfer while the sequencer is idle
  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;

  bhfc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .st    (st),
    .busy  (busy),
    .cw    (cw)
  );

  bhfc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .capture      (in_xfer),
    .ambient_temp (ambient_temp),
    .water_temp   (water_temp),
    .inlet_temp   (inlet_temp),
    .level        (level),
    .cw           (cw),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .heater_power (heater_power),
    .inflow       (inflow),
    .outflow      (outflow)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bhfc_checker.sv @@
`default_nettype none
`include "boiler_heat_and_flow_controller_top_defines.svh"
module bhfc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [20:0] heater_power,
  input wire logic [4:0]         inflow,
  input wire logic [4:0]         outflow
);

  logic [30:0] out_word;
  logic        power_ok;
  logic        heat_pair;
  logic        flow_pair;

  // result fields as one word, and the legal value sets
  assign out_word  = {heater_power, inflow, outflow};
  assign power_ok  = (heater_power <= 21'sd1000000) && (heater_power >= -21'sd1000000);
  assign heat_pair = (inflow == 5'd0) && (outflow == 5'd0);
  assign flow_pair = (heater_power == 21'sd0)
                  && (((inflow == 5'd12) && (outflow == 5'd20))
                   || ((inflow == 5'd15) && (outflow == 5'd10)));

  // a stalled result holds
  `BHFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // one tick at a time: busy right after an input transfer
  `BHFC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // power stays inside the saturation limits
  `BHFC_ASSERT_NOW(a_power_range, out_valid, power_ok)

  // heating gives no flow, flow ticks give a legal pair and no power
  `BHFC_ASSERT_NOW(a_flow_pair, out_valid, heat_pair || flow_pair)

endmodule

bind boiler_heat_and_flow_controller_top bhfc_checker u_checker (.*);
`default_nettype wire

@@ dv/boiler_heat_and_flow_controller_top_tb.sv @@
`timescale 1ns / 100ps
module boiler_heat_and_flow_controller_top_tb;
  import bhfc_pkg::*;

  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     DRAIN_CYCLES = 12;
  localparam longint POWER_MAX    = 1000000;

  // one control tick as seen on the input side
  typedef struct packed {
    logic signed [15:0] ambient;
    logic signed [15:0] water;
    logic signed [15:0] inlet;
    logic [12:0]        lvl;
  } boiler_tick_t;

  // one heater and flow command
  typedef struct packed {
    logic signed [20:0] power;
    logic [4:0]         inflow;
    logic [4:0]         outflow;
  } heat_flow_cmd_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic               cfg_index    = REG_TEMP_TARGET;
  logic [13:0]        cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic signed [15:0] ambient_temp = '0;
  logic signed [15:0] water_temp   = '0;
  logic signed [15:0] inlet_temp   = '0;
  logic [12:0]        level        = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [20:0] heater_power;
  logic [4:0]         inflow;
  logic [4:0]         outflow;

  // controller state as the testbench tracks it
  logic [13:0] temp_set    = '0;
  logic [12:0] level_set   = 13'd2048;
  logic [1:0]  tick_phase  = '0;
  logic [4:0]  prev_inflow = '0;

  heat_flow_cmd_t pending_cmds[$];
  int fail_count  = 0;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;
  int stall_run   = 0;

  boiler_heat_and_flow_controller_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ambient_temp (ambient_temp),
    .water_temp   (water_temp),
    .inlet_temp   (inlet_temp),
    .level        (level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .heater_power (heater_power),
    .inflow       (inflow),
    .outflow      (outflow)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int pick_idle(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // advance the tick counter; on an answering tick compute the command
  function automatic bit predict_cmd(input boiler_tick_t t, output heat_flow_cmd_t c);
    longint tgt, et, eh, num, pw;
    c = '0;
    if (tick_phase != 2'd3) begin
      tick_phase = tick_phase + 2'd1;
      return 1'b0;
    end
    tick_phase = 2'd1;
    tgt = (temp_set > TEMP_MAX) ? longint'(TEMP_MAX) : longint'(temp_set);
    et  = tgt - longint'(t.water);
    eh  = longint'(level_set) - longint'(t.lvl);
    if (et > 0) begin
      // proportional term scaled by level, inflow and ambient compensation
      num = (64'sd1673600 * longint'(t.lvl) + 64'sd40960) * et
          - 64'sd4184 * 64'sd1024 * longint'(prev_inflow)
            * (longint'(t.inlet) - longint'(t.water))
          + 64'sd1024000 * (longint'(t.water) - longint'(t.ambient));
      pw = (num + 64'sd131072) >>> 18;
      if (pw > POWER_MAX) pw = POWER_MAX;
      if (pw < -POWER_MAX) pw = -POWER_MAX;
      c.power = 21'(pw);
    end else if (eh * 20 > 1024) begin
      c.inflow  = INFLOW_HIGH_LEVEL;
      c.outflow = OUTFLOW_HIGH_LEVEL;
    end else begin
      c.inflow  = INFLOW_LOW_LEVEL;
      c.outflow = OUTFLOW_LOW_LEVEL;
    end
    prev_inflow = c.inflow;
    return 1'b1;
  endfunction

  function automatic boiler_tick_t mk_tick(input int a, input int w, input int i, input int l);
    boiler_tick_t t;
    t.ambient = 16'(a);
    t.water   = 16'(w);
    t.inlet   = 16'(i);
    t.lvl     = 13'(l);
    return t;
  endfunction

  // random tick, biased toward the heating and flow decisions
  function automatic boiler_tick_t rand_tick();
    boiler_tick_t t;
    int base, w, lv;
    base      = (temp_set > TEMP_MAX) ? int'(TEMP_MAX) : int'(temp_set);
    t.ambient = 16'(int'($urandom_range(38400)) - 12800);
    t.inlet   = 16'(int'($urandom_range(38400)) - 12800);
    w         = int'($urandom_range(38400)) - 12800;
    lv        = $urandom_range(8191);
    case ($urandom_range(9))
      0: begin
        t.ambient = 16'($urandom);
        t.inlet   = 16'($urandom);
        w         = int'($urandom_range(65535)) - 32768;
      end
      1, 2, 3: begin
        w = base + int'($urandom_range(2000));
        if ($urandom_range(1) == 1) lv = int'(level_set) + int'($urandom_range(120)) - 60;
      end
      4: begin
      end
      default: begin
        w  = base - int'($urandom_range(1, 40));
        lv = $urandom_range(600);
      end
    endcase
    if (lv < 0) lv = 0;
    if (lv > 8191) lv = 8191;
    t.water = 16'(w);
    t.lvl   = 13'(lv);
    return t;
  endfunction

  // offer one tick and wait for its transfer
  task automatic send_tick(input boiler_tick_t t);
    int gap;
    heat_flow_cmd_t c;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    ambient_temp <= t.ambient;
    water_temp   <= t.water;
    inlet_temp   <= t.inlet;
    level        <= t.lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_cmd(t, c)) pending_cmds.push_back(c);
  endtask

  // fill with random ticks so that the given one lands on an answering tick
  task automatic send_answered(input boiler_tick_t t);
    while (tick_phase != 2'd3) send_tick(rand_tick());
    send_tick(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TEMP_TARGET) temp_set = val;
    else level_set = val[12:0];
    @(posedge clk);
  endtask

  // flow choice around the level band, reset set points
  task automatic test_flow_select();
    gap_pct   = 20;
    stall_pct = 20;
    // level far below target
    send_answered(mk_tick(0, 100, 0, 0));
    // zero temperature error, level error just under the band
    send_answered(mk_tick(-12800, 0, 25600, 1997));
    // level error just over the band, field extremes
    send_answered(mk_tick(25600, 32767, -32768, 1996));
    // level far above target, leaves the largest inflow
    send_answered(mk_tick(32767, 200, 0, 8191));
    wait_idle();
  endtask

  // heating with both saturations and the clamped set point
  task automatic test_heat_power();
    write_reg(REG_TEMP_TARGET, 14'h3FFF);
    write_reg(REG_LEVEL_TARGET, 14'h3FFF);
    // hot inflow compensation drives the power to the negative limit
    send_answered(mk_tick(0, 12799, 25600, 0));
    // largest error at full level
    send_answered(mk_tick(32767, -32768, 0, 8191));
    // inside the limits
    send_answered(mk_tick(-12800, 12790, 0, 10));
    wait_idle();
  endtask

  // receiver holds off while ticks keep coming, input must back up
  task automatic test_backpressure();
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 400;
    repeat (40) send_tick(rand_tick());
    wait_idle();
  endtask

  // random ticks over several set point pairs
  task automatic test_random_phases();
    int ph;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TEMP_TARGET, 14'd12800);
          write_reg(REG_LEVEL_TARGET, 14'd0);
        end
        1: begin
          write_reg(REG_TEMP_TARGET, 14'd0);
          write_reg(REG_LEVEL_TARGET, 14'd8191);
        end
        2: begin
          write_reg(REG_TEMP_TARGET, 14'h3FFF);
          write_reg(REG_LEVEL_TARGET, 14'd2048);
        end
        default: begin
          write_reg(REG_TEMP_TARGET, 14'($urandom));
          write_reg(REG_LEVEL_TARGET, 14'($urandom));
        end
      endcase
      gap_pct   = (ph == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = (ph == 0) ? 0 : $urandom_range(10, 50);
      repeat (130) send_tick(rand_tick());
      wait_idle();
    end
  endtask

  // result checking and output stall
  always @(posedge clk) begin
    heat_flow_cmd_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      // compare each transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected command: power %0d inflow %0d outflow %0d",
                     heater_power, inflow, outflow);
        end else begin
          want = pending_cmds.pop_front();
          if (heater_power !== want.power || inflow !== want.inflow ||
              outflow !== want.outflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("command mismatch: power exp %0d got %0d, inflow exp %0d got %0d, %s",
                       want.power, heater_power, want.inflow, inflow,
                       $sformatf("outflow exp %0d got %0d", want.outflow, outflow));
          end
        end
      end
      // next stall value
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        stall_run = pick_idle(stall_pct);
        out_stall <= 1'b0;
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_flow_select();
    test_heat_power();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (fail_count == 0 && pending_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ boiler_heat_and_flow_controller_top.f @@
+incdir+hw/rtl
hw/rtl/bhfc_pkg.sv
hw/rtl/bhfc_sequencer.sv
hw/rtl/bhfc_datapath.sv
hw/rtl/boiler_heat_and_flow_controller_top.sv
hw/rtl/bhfc_checker.sv
dv/boiler_heat_and_flow_controller_top_tb.sv
